@@ rtl/core/slri_pkg.sv @@
// Package for the sorted list insert/remove core.
// Holds sizes, command and status codes, the state type and the cell control bundle.
// Depends on nothing; every other file of the block imports it.
package slri_pkg;

    // Store size and field widths.
    localparam int CAPACITY = 64;
    localparam int ValueW   = 32;
    localparam int CountW   = $clog2(CAPACITY + 1);
    localparam int PosW     = 7;
    localparam int CntOutW  = 7;

    typedef logic signed [ValueW-1:0] value_t;
    typedef logic signed [PosW-1:0]   pos_t;
    typedef logic [CountW-1:0]        count_t;
    typedef logic [CntOutW-1:0]       count_out_t;

    // Request commands.
    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    // Sequencer states.
    typedef enum logic {
        S_IDLE  = 1'b0,
        S_APPLY = 1'b1
    } state_t;

    // Control broadcast from the sequencer to every cell of the row.
    typedef struct packed {
        logic   capture;
        logic   insert_en;
        logic   remove_en;
        value_t value;
    } cell_ctrl_t;

endpackage

@@ rtl/core/slri_req_if.sv @@
// Request channel interface: valid/ready handshake with command and value.
// Depends on slri_pkg.
interface slri_req_if;
    import slri_pkg::*;

    logic   valid;
    logic   ready;
    cmd_t   command;
    value_t value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

@@ rtl/core/slri_rsp_if.sv @@
// Response channel interface: valid/ready handshake with the result fields.
// Depends on slri_pkg.
interface slri_rsp_if;
    import slri_pkg::*;

    logic       valid;
    logic       ready;
    pos_t       position;
    status_t    status;
    count_out_t element_count;
    logic       is_empty_flag;

    modport source (output valid, output position, output status, output element_count,
                    output is_empty_flag, input ready);
    modport sink   (input valid, input position, input status, input element_count,
                    input is_empty_flag, output ready);
endinterface

@@ rtl/core/slri_cell.sv @@
// One storage cell of the ordered row: holds a value and its comparison flags.
// Depends on slri_pkg; instantiated once per entry by the top level.
module slri_cell (
    input  logic                clk,
    input  slri_pkg::cell_ctrl_t ctrl,
    input  logic                occupied,
    input  logic                left_lt,
    input  slri_pkg::value_t    left_value,
    input  slri_pkg::value_t    right_value,
    output logic                lt,
    output logic                eq,
    output slri_pkg::value_t    value
);
    import slri_pkg::*;

    value_t value_reg, value_next;
    logic   lt_reg, lt_next;
    logic   eq_reg, eq_next;

    // Compare against the incoming value, or shift one place during the update.
    always_comb
    begin
        value_next = value_reg;
        lt_next    = lt_reg;
        eq_next    = eq_reg;
        priority if (ctrl.capture)
        begin
            lt_next = occupied && (value_reg < ctrl.value);
            eq_next = occupied && (value_reg == ctrl.value);
        end
        else if (ctrl.insert_en && !lt_reg)
        begin
            // The first cell not smaller than the new value takes it; later cells move right.
            value_next = left_lt ? ctrl.value : left_value;
        end
        else if (ctrl.remove_en && !lt_reg)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        lt_reg    <= lt_next;
        eq_reg    <= eq_next;
    end

    assign lt    = lt_reg;
    assign eq    = eq_reg;
    assign value = value_reg;

endmodule

@@ rtl/core/slri_enc.sv @@
// Boundary encoder: turns the prefix of "smaller" flags into the count of smaller entries.
// Depends on slri_pkg.
module slri_enc (
    input  logic [slri_pkg::CAPACITY-1:0] lt,
    output slri_pkg::count_t              idx
);
    import slri_pkg::*;

    logic [CAPACITY:0] boundary;

    // Mark the single place where the flags change from set to clear.
    always_comb
    begin
        boundary[0]        = !lt[0];
        boundary[CAPACITY] = lt[CAPACITY-1];
        for (int i = 1; i < CAPACITY; i++)
        begin
            boundary[i] = lt[i-1] && !lt[i];
        end
    end

    // One-hot to binary: an OR over the marked positions.
    always_comb
    begin
        idx = '0;
        for (int i = 0; i <= CAPACITY; i++)
        begin
            idx = idx | (boundary[i] ? count_t'(i) : count_t'(0));
        end
    end

endmodule

@@ rtl/core/sorted_list_insert_remove_core.sv @@
// Top level of the sorted list insert/remove core: sequencer, row of cells, result register.
// Depends on slri_pkg, slri_req_if, slri_rsp_if, slri_cell and slri_enc.
//
//   channel | direction | payload
//   req     | in        | command, value
//   rsp     | out       | position, status, element_count, is_empty_flag
//
// For each item, every cell compares against the request in the cycle it is accepted, and
// the row shifts and the result is registered in the S_APPLY update state that follows.
// A new request is accepted only in S_IDLE, after the previous item has been committed.
// If the previous result has not been taken, the update cycle waits until it is.
// Reset empties the store at once through the element count; no clearing pass is needed.
module sorted_list_insert_remove_core (
    input logic              clk,
    input logic              rst_n,
    slri_req_if.sink         req,
    slri_rsp_if.source       rsp
);
    import slri_pkg::*;

    state_t     state_reg, state_next;
    cmd_t       cmd_reg, cmd_next;
    value_t     val_reg, val_next;
    count_t     count_reg, count_next;
    logic       rsp_valid_reg, rsp_valid_next;
    pos_t       rsp_pos_reg, rsp_pos_next;
    status_t    rsp_status_reg, rsp_status_next;
    count_out_t rsp_count_reg, rsp_count_next;
    logic       rsp_empty_reg, rsp_empty_next;

    cell_ctrl_t            ctrl;
    logic [CAPACITY-1:0]   lt_vec;
    logic [CAPACITY-1:0]   eq_vec;
    logic [CAPACITY-1:0]   occ_vec;
    value_t                cell_value [CAPACITY];
    count_t                smaller_cnt;
    logic                  full;
    logic                  found;
    logic                  commit;

    // Row of cells, each wired to its neighbours.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic   left_lt;
        value_t left_value;
        value_t right_value;

        assign occ_vec[i] = count_t'(i) < count_reg;

        if (i == 0)
        begin : g_first
            assign left_lt    = 1'b1;
            assign left_value = ctrl.value;
        end
        else
        begin : g_mid
            assign left_lt    = lt_vec[i-1];
            assign left_value = cell_value[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_value = cell_value[i];
        end
        else
        begin : g_inner
            assign right_value = cell_value[i+1];
        end

        slri_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .occupied    (occ_vec[i]),
            .left_lt     (left_lt),
            .left_value  (left_value),
            .right_value (right_value),
            .lt          (lt_vec[i]),
            .eq          (eq_vec[i]),
            .value       (cell_value[i])
        );
    end

    // Number of stored entries smaller than the request value.
    slri_enc u_enc (
        .lt  (lt_vec),
        .idx (smaller_cnt)
    );

    assign full  = (count_reg == count_t'(CAPACITY));
    assign found = |eq_vec;

    // Sequencer: next state, cell control and result.
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        val_next        = val_reg;
        count_next      = count_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_pos_next    = rsp_pos_reg;
        rsp_status_next = rsp_status_reg;
        rsp_count_next  = rsp_count_reg;
        rsp_empty_next  = rsp_empty_reg;
        req.ready       = 1'b0;
        commit          = 1'b0;
        ctrl.capture    = 1'b0;
        ctrl.insert_en  = 1'b0;
        ctrl.remove_en  = 1'b0;
        ctrl.value      = val_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                req.ready  = 1'b1;
                ctrl.value = req.value;
                if (req.valid)
                begin
                    ctrl.capture = 1'b1;
                    cmd_next     = req.command;
                    val_next     = req.value;
                    state_next   = S_APPLY;
                end
            end
            S_APPLY:
            begin
                commit = !rsp_valid_reg || rsp.ready;
                if (commit)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    rsp_pos_next   = pos_t'(-1);
                    if (cmd_reg == CMD_INSERT)
                    begin
                        if (full)
                        begin
                            rsp_status_next = ST_FULL;
                        end
                        else
                        begin
                            ctrl.insert_en  = 1'b1;
                            count_next      = count_reg + count_t'(1);
                            rsp_status_next = ST_DONE;
                            rsp_pos_next    = pos_t'(smaller_cnt) - pos_t'(1);
                        end
                    end
                    else
                    begin
                        if (found)
                        begin
                            ctrl.remove_en  = 1'b1;
                            count_next      = count_reg - count_t'(1);
                            rsp_status_next = ST_DONE;
                            rsp_pos_next    = pos_t'(smaller_cnt);
                        end
                        else
                        begin
                            rsp_status_next = ST_NOT_FOUND;
                        end
                    end
                    rsp_count_next = count_out_t'(count_next);
                    rsp_empty_next = (count_next == '0);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Request and result payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        val_reg        <= val_next;
        rsp_pos_reg    <= rsp_pos_next;
        rsp_status_reg <= rsp_status_next;
        rsp_count_reg  <= rsp_count_next;
        rsp_empty_reg  <= rsp_empty_next;
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.position      = rsp_pos_reg;
    assign rsp.status        = rsp_status_reg;
    assign rsp.element_count = rsp_count_reg;
    assign rsp.is_empty_flag = rsp_empty_reg;

    // The store never holds more than its capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= count_t'(CAPACITY))
        else $error("element count above capacity");

    // The "smaller" flags form a prefix when the row is updated, as the order demands.
    a_lt_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_APPLY |-> (lt_vec & (lt_vec + CAPACITY'(1))) == '0)
        else $error("comparison flags are not a prefix");

    // A new result appears only from the update cycle.
    a_rsp_from_apply: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg) == S_APPLY)
        else $error("result raised outside the update cycle");

    // A full report means the store really is full.
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_status_reg == ST_FULL |-> full)
        else $error("full status with room in the store");

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the sorted list insert/remove core.
// Depends on slri_pkg, slri_req_if, slri_rsp_if and sorted_list_insert_remove_core.
// An order tracker keeps its own sorted copy of the store and checks each result as it arrives.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import slri_pkg::*;

    localparam int TARGET_REQUESTS = 1700;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int MAX_REPORTS     = 10;

    // One expected response transfer.
    typedef struct {
        pos_t       position;
        status_t    status;
        count_out_t element_count;
        logic       is_empty_flag;
    } list_result_t;

    // Tracks the ordered contents and the results still to come back.
    class order_tracker;
        value_t       held_values[$];
        list_result_t awaited[$];
        int           mismatches;
        int           checked;
        int           placed;
        int           refused_full;
        int           missed_remove;

        function new();
            mismatches    = 0;
            checked       = 0;
            placed        = 0;
            refused_full  = 0;
            missed_remove = 0;
        endfunction

        // Applies an accepted request to the tracked store and queues its result.
        function void note_request(cmd_t command, value_t value);
            list_result_t r;
            int           below;
            below = 0;
            while (below < held_values.size() && held_values[below] < value)
                below++;
            r.position = pos_t'(-1);
            r.status   = ST_DONE;
            if (command == CMD_INSERT)
            begin
                if (held_values.size() >= CAPACITY)
                begin
                    r.status = ST_FULL;
                    refused_full++;
                end
                else
                begin
                    held_values.insert(below, value);
                    r.position = pos_t'(below - 1);
                    placed++;
                end
            end
            else
            begin
                if (below < held_values.size() && held_values[below] == value)
                begin
                    held_values.delete(below);
                    r.position = pos_t'(below);
                end
                else
                begin
                    r.status = ST_NOT_FOUND;
                    missed_remove++;
                end
            end
            r.element_count = count_out_t'(held_values.size());
            r.is_empty_flag = (held_values.size() == 0);
            awaited.push_back(r);
        endfunction

        // Compares a response transfer with the oldest awaited result.
        function void check_result(list_result_t got);
            list_result_t want;
            checked++;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result with nothing awaited: pos %0d status %0d count %0d",
                             got.position, got.status, got.element_count);
                return;
            end
            want = awaited.pop_front();
            if (got.position !== want.position || got.status !== want.status ||
                got.element_count !== want.element_count ||
                got.is_empty_flag !== want.is_empty_flag)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"result %0d: want pos %0d st %0d cnt %0d empty %0b,",
                              " got pos %0d st %0d cnt %0d empty %0b"},
                             checked, want.position, want.status, want.element_count,
                             want.is_empty_flag, got.position, got.status,
                             got.element_count, got.is_empty_flag);
            end
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   idle_pct;
    int   cycles = 0;
    int   sent;

    order_tracker tracker;

    slri_req_if req ();
    slri_rsp_if rsp ();

    sorted_list_insert_remove_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Cycle counter with a watchdog on hung runs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // Response side: check each completed transfer and stall at random.
    always @(posedge clk)
    begin
        list_result_t got;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got.position      = rsp.position;
            got.status        = rsp.status;
            got.element_count = rsp.element_count;
            got.is_empty_flag = rsp.is_empty_flag;
            tracker.check_result(got);
        end
        rsp.ready <= ($urandom_range(99) >= idle_pct);
    end

    // Presents one request, with a random idle gap first, and waits for its transfer.
    task automatic send(cmd_t command, value_t value);
        while ($urandom_range(99) < idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid   <= 1'b1;
        req.command <= command;
        req.value   <= value;
        do
            @(posedge clk);
        while (!req.ready);
        tracker.note_request(command, value);
        sent++;
    endtask

    // Draws a value: most often a narrow band for duplicates, else wide, extreme or already held.
    function automatic value_t pick_value();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40)
            return value_t'(int'($urandom_range(40)) - 20);
        if (sel < 70)
            return value_t'($urandom);
        if (sel < 85)
        begin
            case ($urandom_range(3))
                0: return 32'sh7fffffff - value_t'($urandom_range(2));
                1: return 32'sh80000000 + value_t'($urandom_range(2));
                2: return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        if (tracker.held_values.size() > 0)
            return tracker.held_values[$urandom_range(tracker.held_values.size() - 1)];
        return value_t'($urandom);
    endfunction

    // A remove mostly names a value that is held.
    function automatic value_t pick_victim();
        if (tracker.held_values.size() > 0 && $urandom_range(99) < 85)
            return tracker.held_values[$urandom_range(tracker.held_values.size() - 1)];
        return pick_value();
    endfunction

    // Reset, directed requests, then random episodes of filling, draining and mixing.
    initial
    begin
        int ep;
        int kind;
        tracker     = new();
        sent        = 0;
        idle_pct    = 20;
        rst_n       <= 1'b0;
        req.valid   <= 1'b0;
        req.command <= CMD_INSERT;
        req.value   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty store, head and tail placement, duplicates, extremes.
        send(CMD_REMOVE, 32'sd5);
        send(CMD_INSERT, 32'sd0);
        send(CMD_INSERT, 32'sh7fffffff);
        send(CMD_INSERT, 32'sh80000000);
        send(CMD_INSERT, 32'sd0);
        send(CMD_INSERT, -32'sd1);
        send(CMD_INSERT, 32'sh7fffffff);
        send(CMD_REMOVE, 32'sd0);
        send(CMD_REMOVE, 32'sd7);
        send(CMD_REMOVE, 32'sh7fffffff);
        send(CMD_REMOVE, 32'sh80000000);
        send(CMD_INSERT, 32'sh55555555);
        send(CMD_INSERT, 32'shaaaaaaaa);
        send(CMD_REMOVE, 32'sh55555554);
        send(CMD_REMOVE, 32'shaaaaaaaa);
        send(CMD_REMOVE, 32'sh55555555);
        send(CMD_REMOVE, -32'sd1);
        send(CMD_REMOVE, 32'sh7fffffff);
        send(CMD_REMOVE, 32'sd0);
        send(CMD_REMOVE, 32'sd0);

        // Random episodes; a few in the middle run with no idling on either side.
        ep = 0;
        while (sent < TARGET_REQUESTS)
        begin
            idle_pct = (ep >= 8 && ep < 12) ? 0 : 20;
            if (ep == 0)
                kind = 0;
            else if (ep == 1)
                kind = 1;
            else
                kind = $urandom_range(2);
            case (kind)
                0:
                begin
                    while (tracker.held_values.size() < CAPACITY)
                        send(CMD_INSERT, pick_value());
                    repeat ($urandom_range(3, 1)) send(CMD_INSERT, pick_value());
                end
                1:
                begin
                    while (tracker.held_values.size() > 0)
                    begin
                        if ($urandom_range(99) < 10)
                            send(CMD_REMOVE, value_t'($urandom));
                        else
                            send(CMD_REMOVE, tracker.held_values[
                                $urandom_range(tracker.held_values.size() - 1)]);
                    end
                    send(CMD_REMOVE, pick_value());
                end
                default:
                begin
                    repeat ($urandom_range(80, 20))
                    begin
                        if ($urandom_range(99) < 55)
                            send(CMD_INSERT, pick_value());
                        else
                            send(CMD_REMOVE, pick_victim());
                    end
                end
            endcase
            ep++;
        end
        req.valid <= 1'b0;

        // Drain the outstanding results, then wait for anything stray.
        while (tracker.outstanding() > 0)
            @(posedge clk);
        repeat (6) @(posedge clk);

        $display("summary: %0d requests in %0d episodes, %0d results checked",
                 sent, ep, tracker.checked);
        $display("summary: %0d placed, %0d refused as full, %0d removes not found",
                 tracker.placed, tracker.refused_full, tracker.missed_remove);
        if (tracker.mismatches == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
